>>> hw/rtl/bscu_pkg.sv
// ----------------------------------------------------------------------------
// bscu_pkg
// Shared widths, register indexes, constants and the signed power-of-two
// divide used by the barometric compensation pipeline.
// ----------------------------------------------------------------------------
package bscu_pkg;

  // divider geometry
  localparam int TDIV_NW = 27;  // |MC * 2048|
  localparam int TDIV_DW = 20;  // |X1 + MD|
  localparam int TDIV_PW = 45;  // up, x1, sign, zero flag
  localparam int PDIV_NW = 32;  // B7 or B7 * 2
  localparam int PDIV_DW = 17;  // B4
  localparam int PDIV_PW = 19;  // b7 msb, b4 zero, t, t zero

  // register stages from the start edge to the done strobe
  localparam int PIPE_DEPTH = 3 + TDIV_NW + 8 + PDIV_NW + 4;

  localparam logic [2:0] REG_AC1_AC2      = 3'd0;
  localparam logic [2:0] REG_AC3_AC4      = 3'd1;
  localparam logic [2:0] REG_AC5_AC6      = 3'd2;
  localparam logic [2:0] REG_B1_B2        = 3'd3;
  localparam logic [2:0] REG_MC_MD        = 3'd4;
  localparam logic [2:0] REG_OVERSAMPLING = 3'd5;

  localparam logic signed [29:0] B6_OFFSET   = 30'sd4000;
  localparam logic [15:0]         PRESS_SCALE = 16'd50000;
  localparam logic [31:0]         X3_BIAS     = 32'd32768;
  localparam logic signed [12:0]  P_SQ_COEF   = 13'sd3038;
  localparam logic signed [14:0]  P_LIN_COEF  = -15'sd7357;
  localparam logic signed [63:0]  P_OFFSET    = 64'sd3791;
  localparam logic signed [63:0]  T_MAX       = 64'sd32767;
  localparam logic signed [63:0]  T_MIN       = -64'sd32768;
  localparam logic signed [63:0]  P_MAX       = 64'sd262143;

  // signed divide by 2^k, truncating toward zero
  function automatic logic signed [63:0] sdiv_p2(input logic signed [63:0] v,
                                                 input logic [5:0] k);
    logic signed [63:0] bias;
    bias = v[63] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
    return (v + bias) >>> k;
  endfunction

endpackage

>>> hw/rtl/barometric_sensor_compensation_unit.sv
// ----------------------------------------------------------------------------
// barometric_sensor_compensation_unit
// Integer temperature and pressure compensation of raw barometer samples.
// ----------------------------------------------------------------------------
// channel   ports                                          handshake
// input     start, busy, raw_temperature, raw_pressure     start & !busy
// result    done, temperature_tenths, pressure_pa,         done strobe, 1 cycle
//           divide_error
// config    cfg_valid, cfg_ready, cfg_index, cfg_data      cfg_valid & cfg_ready
//
// One word per cycle enters and moves through PIPE_DEPTH register stages to done.
// Latency is set by the two bit-per-stage dividers (27 and 32 stages) plus
// the multiply stages around them. busy stays low; cfg_ready stays high.
// Synchronous reset clears the valid chain and the coefficient registers.
// ----------------------------------------------------------------------------
module barometric_sensor_compensation_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] raw_temperature,
  input  logic [23:0] raw_pressure,
  output logic        done,
  output logic signed [15:0] temperature_tenths,
  output logic [17:0] pressure_pa,
  output logic        divide_error,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import bscu_pkg::*;

  // configuration
  logic [31:0] coef_ac1_ac2, coef_ac3_ac4, coef_ac5_ac6, coef_b1_b2, coef_mc_md;
  logic [1:0]  oversampling;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_ac1_ac2 <= '0;
      coef_ac3_ac4 <= '0;
      coef_ac5_ac6 <= '0;
      coef_b1_b2   <= '0;
      coef_mc_md   <= '0;
      oversampling <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_AC1_AC2:      coef_ac1_ac2 <= cfg_data;
        REG_AC3_AC4:      coef_ac3_ac4 <= cfg_data;
        REG_AC5_AC6:      coef_ac5_ac6 <= cfg_data;
        REG_B1_B2:        coef_b1_b2   <= cfg_data;
        REG_MC_MD:        coef_mc_md   <= cfg_data;
        REG_OVERSAMPLING: oversampling <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
  logic [15:0]        ac4, ac5, ac6;

  assign ac1 = $signed(coef_ac1_ac2[31:16]);
  assign ac2 = $signed(coef_ac1_ac2[15:0]);
  assign ac3 = $signed(coef_ac3_ac4[31:16]);
  assign ac4 = coef_ac3_ac4[15:0];
  assign ac5 = coef_ac5_ac6[31:16];
  assign ac6 = coef_ac5_ac6[15:0];
  assign b1  = $signed(coef_b1_b2[31:16]);
  assign b2  = $signed(coef_b1_b2[15:0]);
  assign mc  = $signed(coef_mc_md[31:16]);
  assign md  = $signed(coef_mc_md[15:0]);

  // stage valid chain outside the dividers
  logic v0, v1, v2, v3, v4, v5, v6, v7, v8, v9, v10, v12, v13, v14;
  logic tdiv_vld, pdiv_vld;

  // ---------------- S0: capture
  logic [15:0] s0_ut;
  logic [23:0] s0_up;

  always_ff @(posedge clk) begin
    s0_ut <= raw_temperature;
    s0_up <= raw_pressure >> (4'd8 - {2'b00, oversampling});
  end

  // ---------------- S1: (UT - AC6) * AC5
  logic signed [17:0] s0_diff;
  logic signed [34:0] s1_prod;
  logic [23:0]        s1_up;

  assign s0_diff = $signed({2'b00, s0_ut}) - $signed({2'b00, ac6});

  always_ff @(posedge clk) begin
    s1_prod <= s0_diff * $signed({1'b0, ac5});
    s1_up   <= s0_up;
  end

  // ---------------- S2: divider operands, sign and magnitude
  logic signed [63:0] s1_x1w;
  logic signed [18:0] s1_x1;
  logic signed [19:0] s1_den;
  logic signed [26:0] s1_num;
  logic [26:0]        s2_num_mag;
  logic [19:0]        s2_den_mag;
  logic               s2_neg, s2_tz;
  logic signed [18:0] s2_x1;
  logic [23:0]        s2_up;

  assign s1_x1w = sdiv_p2(64'(s1_prod), 6'd15);
  assign s1_x1  = s1_x1w[18:0];
  assign s1_den = 20'(s1_x1) + 20'(md);
  assign s1_num = {mc, 11'b0};

  always_ff @(posedge clk) begin
    s2_num_mag <= s1_num[26] ? 27'(-s1_num) : s1_num;
    s2_den_mag <= s1_den[19] ? 20'(-s1_den) : s1_den;
    s2_neg     <= s1_num[26] ^ s1_den[19];
    s2_tz      <= (s1_den == '0);
    s2_x1      <= s1_x1;
    s2_up      <= s1_up;
  end

  logic [TDIV_NW-1:0] tdiv_q;
  logic [TDIV_PW-1:0] tdiv_pay;

  bscu_div #(.NW(TDIV_NW), .DW(TDIV_DW), .PW(TDIV_PW)) u_tdiv (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (v2),
    .dividend    (s2_num_mag),
    .divisor     (s2_den_mag),
    .payload_in  ({s2_up, s2_x1, s2_neg, s2_tz}),
    .out_valid   (tdiv_vld),
    .quotient    (tdiv_q),
    .payload_out (tdiv_pay)
  );

  // ---------------- S3: B5, T, B6
  logic [23:0]        td_up;
  logic signed [18:0] td_x1;
  logic               td_neg, td_tz;
  logic signed [27:0] td_x2;
  logic signed [28:0] td_b5;
  logic signed [63:0] td_tw;
  logic signed [15:0] s3_t;
  logic signed [29:0] s3_b6;
  logic [23:0]        s3_up;
  logic               s3_tz;

  assign {td_up, td_x1, td_neg, td_tz} = tdiv_pay;
  assign td_x2 = td_neg ? -$signed({1'b0, tdiv_q}) : $signed({1'b0, tdiv_q});
  assign td_b5 = 29'(td_x1) + 29'(td_x2);
  assign td_tw = sdiv_p2(64'(td_b5) + 64'sd8, 6'd4);

  always_ff @(posedge clk) begin
    if (td_tw > T_MAX) begin
      s3_t <= 16'sh7fff;
    end else if (td_tw < T_MIN) begin
      s3_t <= 16'sh8000;
    end else begin
      s3_t <= td_tw[15:0];
    end
    s3_b6 <= 30'(td_b5) - B6_OFFSET;
    s3_up <= td_up;
    s3_tz <= td_tz;
  end

  // ---------------- S4: B6 products
  logic signed [59:0] s4_sqf;
  logic signed [45:0] s4_ac2b6, s4_ac3b6;
  logic signed [15:0] s4_t;
  logic [23:0]        s4_up;
  logic               s4_tz;

  always_ff @(posedge clk) begin
    s4_sqf   <= s3_b6 * s3_b6;
    s4_ac2b6 <= ac2 * s3_b6;
    s4_ac3b6 <= ac3 * s3_b6;
    s4_t     <= s3_t;
    s4_up    <= s3_up;
    s4_tz    <= s3_tz;
  end

  // ---------------- S5: scale
  logic signed [47:0] s5_sq;
  logic signed [63:0] s5_xa2, s5_xa3;
  logic signed [15:0] s5_t;
  logic [23:0]        s5_up;
  logic               s5_tz;

  always_ff @(posedge clk) begin
    s5_sq  <= 48'(s4_sqf >>> 12);
    s5_xa2 <= sdiv_p2(64'(s4_ac2b6), 6'd11);
    s5_xa3 <= sdiv_p2(64'(s4_ac3b6), 6'd13);
    s5_t   <= s4_t;
    s5_up  <= s4_up;
    s5_tz  <= s4_tz;
  end

  // ---------------- S6: B2 * sq, B1 * sq
  logic signed [63:0] s6_b2sq, s6_b1sq, s6_xa2, s6_xa3;
  logic signed [15:0] s6_t;
  logic [23:0]        s6_up;
  logic               s6_tz;

  always_ff @(posedge clk) begin
    s6_b2sq <= b2 * s5_sq;
    s6_b1sq <= b1 * s5_sq;
    s6_xa2  <= s5_xa2;
    s6_xa3  <= s5_xa3;
    s6_t    <= s5_t;
    s6_up   <= s5_up;
    s6_tz   <= s5_tz;
  end

  // ---------------- S7: X3 sums
  logic signed [63:0] s7_x3, s7_xsum;
  logic signed [15:0] s7_t;
  logic [23:0]        s7_up;
  logic               s7_tz;

  always_ff @(posedge clk) begin
    s7_x3   <= sdiv_p2(s6_b2sq, 6'd11) + s6_xa2;
    s7_xsum <= s6_xa3 + sdiv_p2(s6_b1sq, 6'd16) + 64'sd2;
    s7_t    <= s6_t;
    s7_up   <= s6_up;
    s7_tz   <= s6_tz;
  end

  // ---------------- S8: B3 and the B4 term
  logic signed [63:0] s8_b3, s8_x3b;
  logic signed [15:0] s8_t;
  logic [23:0]        s8_up;
  logic               s8_tz;

  always_ff @(posedge clk) begin
    s8_b3  <= sdiv_p2((((64'(ac1) <<< 2) + s7_x3) <<< oversampling) + 64'sd2, 6'd2);
    s8_x3b <= sdiv_p2(s7_xsum, 6'd2);
    s8_t   <= s7_t;
    s8_up  <= s7_up;
    s8_tz  <= s7_tz;
  end

  // ---------------- S9: B4, UP - B3 (both mod 2^32)
  logic [47:0]        s8_b4p;
  logic signed [63:0] s8_upd;
  logic [16:0]        s9_b4;
  logic [31:0]        s9_upb;
  logic signed [15:0] s9_t;
  logic               s9_tz;

  assign s8_b4p = ac4 * (s8_x3b[31:0] + X3_BIAS);
  assign s8_upd = $signed({40'b0, s8_up}) - s8_b3;

  always_ff @(posedge clk) begin
    s9_b4  <= s8_b4p[31:15];
    s9_upb <= s8_upd[31:0];
    s9_t   <= s8_t;
    s9_tz  <= s8_tz;
  end

  // ---------------- S10: B7
  logic [47:0]        s9_b7p;
  logic [31:0]        s10_b7;
  logic [16:0]        s10_b4;
  logic               s10_b4z;
  logic signed [15:0] s10_t;
  logic               s10_tz;

  assign s9_b7p = s9_upb * (PRESS_SCALE >> oversampling);

  always_ff @(posedge clk) begin
    s10_b7  <= s9_b7p[31:0];
    s10_b4  <= s9_b4;
    s10_b4z <= (s9_b4 == '0);
    s10_t   <= s9_t;
    s10_tz  <= s9_tz;
  end

  logic [PDIV_NW-1:0] pdiv_q;
  logic [PDIV_PW-1:0] pdiv_pay;

  // below 2^31 the word is doubled before the divide, else the quotient is doubled after it
  bscu_div #(.NW(PDIV_NW), .DW(PDIV_DW), .PW(PDIV_PW)) u_pdiv (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (v10),
    .dividend    (s10_b7[31] ? s10_b7 : {s10_b7[30:0], 1'b0}),
    .divisor     (s10_b4),
    .payload_in  ({s10_b7[31], s10_b4z, s10_t, s10_tz}),
    .out_valid   (pdiv_vld),
    .quotient    (pdiv_q),
    .payload_out (pdiv_pay)
  );

  // ---------------- S12: p, (p/256)^2, -7357 * p
  logic               pd_msb, pd_b4z, pd_tz;
  logic signed [15:0] pd_t;
  logic signed [31:0] pd_p;
  logic signed [63:0] pd_pdw;
  logic signed [23:0] pd_pd;
  logic signed [31:0] s12_p;
  logic signed [47:0] s12_sq2;
  logic signed [46:0] s12_m2;
  logic signed [15:0] s12_t;
  logic               s12_err;

  assign {pd_msb, pd_b4z, pd_t, pd_tz} = pdiv_pay;
  assign pd_p   = pd_msb ? $signed({pdiv_q[30:0], 1'b0}) : $signed(pdiv_q);
  assign pd_pdw = sdiv_p2(64'(pd_p), 6'd8);
  assign pd_pd  = pd_pdw[23:0];

  always_ff @(posedge clk) begin
    s12_p   <= pd_p;
    s12_sq2 <= pd_pd * pd_pd;
    s12_m2  <= P_LIN_COEF * pd_p;
    s12_t   <= pd_t;
    s12_err <= pd_tz | pd_b4z;
  end

  // ---------------- S13
  logic signed [59:0] s13_x1m;
  logic signed [63:0] s13_x2;
  logic signed [31:0] s13_p;
  logic signed [15:0] s13_t;
  logic               s13_err;

  always_ff @(posedge clk) begin
    s13_x1m <= s12_sq2 * P_SQ_COEF;
    s13_x2  <= sdiv_p2(64'(s12_m2), 6'd16);
    s13_p   <= s12_p;
    s13_t   <= s12_t;
    s13_err <= s12_err;
  end

  // ---------------- S14
  logic signed [63:0] s14_s;
  logic signed [31:0] s14_p;
  logic signed [15:0] s14_t;
  logic               s14_err;

  always_ff @(posedge clk) begin
    s14_s   <= sdiv_p2(64'(s13_x1m), 6'd16) + s13_x2 + P_OFFSET;
    s14_p   <= s13_p;
    s14_t   <= s13_t;
    s14_err <= s13_err;
  end

  // ---------------- S15: final pressure, saturate, output word
  logic signed [63:0] s14_pf;

  assign s14_pf = 64'(s14_p) + sdiv_p2(s14_s, 6'd4);

  always_ff @(posedge clk) begin
    divide_error <= s14_err;
    if (s14_err) begin
      temperature_tenths <= '0;
      pressure_pa        <= '0;
    end else begin
      temperature_tenths <= s14_t;
      if (s14_pf < 64'sd0) begin
        pressure_pa <= '0;
      end else if (s14_pf > P_MAX) begin
        pressure_pa <= '1;
      end else begin
        pressure_pa <= s14_pf[17:0];
      end
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v0   <= 1'b0;
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      v5   <= 1'b0;
      v6   <= 1'b0;
      v7   <= 1'b0;
      v8   <= 1'b0;
      v9   <= 1'b0;
      v10  <= 1'b0;
      v12  <= 1'b0;
      v13  <= 1'b0;
      v14  <= 1'b0;
      done <= 1'b0;
    end else begin
      v0   <= start && !busy;
      v1   <= v0;
      v2   <= v1;
      v3   <= tdiv_vld;
      v4   <= v3;
      v5   <= v4;
      v6   <= v5;
      v7   <= v6;
      v8   <= v7;
      v9   <= v8;
      v10  <= v9;
      v12  <= pdiv_vld;
      v13  <= v12;
      v14  <= v13;
      done <= v14;
    end
  end

endmodule

>>> hw/rtl/bscu_div.sv
// ----------------------------------------------------------------------------
// bscu_div
// Pipelined unsigned restoring divider, one quotient bit per stage, with a
// payload that travels alongside the operands.
// ----------------------------------------------------------------------------
module bscu_div #(
  parameter int NW = 32,
  parameter int DW = 16,
  parameter int PW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  input  logic [PW-1:0] payload_in,
  output logic          out_valid,
  output logic [NW-1:0] quotient,
  output logic [PW-1:0] payload_out
);

  logic [NW-1:0] num_q [NW];
  logic [DW-1:0] rem_q [NW];
  logic [NW-1:0] quo_q [NW];
  logic [DW-1:0] dvs_q [NW];
  logic [PW-1:0] pay_q [NW];
  logic [NW-1:0] vld_q;

  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic [NW-1:0] num_in;
    logic [DW-1:0] rem_in;
    logic [NW-1:0] quo_in;
    logic [DW-1:0] dvs_in;
    logic [PW-1:0] pay_in;
    logic          vld_in;
    logic [DW:0]   trial;
    logic [DW:0]   diff;

    if (i == 0) begin : g_first
      assign num_in = dividend;
      assign rem_in = '0;
      assign quo_in = '0;
      assign dvs_in = divisor;
      assign pay_in = payload_in;
      assign vld_in = in_valid;
    end else begin : g_next
      assign num_in = num_q[i-1];
      assign rem_in = rem_q[i-1];
      assign quo_in = quo_q[i-1];
      assign dvs_in = dvs_q[i-1];
      assign pay_in = pay_q[i-1];
      assign vld_in = vld_q[i-1];
    end

    assign trial = {rem_in, num_in[NW-1]};
    assign diff  = trial - {1'b0, dvs_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= vld_in;
      end
    end

    // borrow set: divisor did not fit, keep the shifted remainder
    always_ff @(posedge clk) begin
      num_q[i] <= num_in << 1;
      rem_q[i] <= diff[DW] ? trial[DW-1:0] : diff[DW-1:0];
      quo_q[i] <= {quo_in[NW-2:0], ~diff[DW]};
      dvs_q[i] <= dvs_in;
      pay_q[i] <= pay_in;
    end
  end

  assign out_valid   = vld_q[NW-1];
  assign quotient    = quo_q[NW-1];
  assign payload_out = pay_q[NW-1];

endmodule

>>> hw/rtl/bscu_checker.sv
// ----------------------------------------------------------------------------
// bscu_checker
// Port-level checks on the compensation unit: fixed latency, no spurious results, error words, cfg_ready.
// ----------------------------------------------------------------------------
module bscu_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic signed [15:0] temperature_tenths,
  input logic [17:0] pressure_pa,
  input logic        divide_error,
  input logic        cfg_valid,
  input logic        cfg_ready
);
  import bscu_pkg::*;

  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##PIPE_DEPTH done)
    else $error("accepted word produced no result at fixed latency");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, PIPE_DEPTH))
    else $error("result word without an accepted input");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    done && divide_error |-> temperature_tenths == 16'sd0 && pressure_pa == 18'd0)
    else $error("divide error word carries nonzero results");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("config write stalled");

endmodule

bind barometric_sensor_compensation_unit bscu_checker u_bscu_checker (.*);
